/* src/scfb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_pkg: speed command frame builder shared types
// Beat types for the command and byte channels, config register indexes and
// the frame slot sequence.
// ----------------------------------------------------------------------------
package scfb_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 8;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_BYTE     = 2'd0,
		CFG_END_BYTE       = 2'd1,
		CFG_SET_SPEED_CODE = 2'd2,
		CFG_FORWARD_CODE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] set_speed_code;
		logic [7:0] forward_code;
	} cfg_regs_t;

	typedef struct packed {
		logic               func;
		logic [7:0]         target_id;
		logic signed [31:0] speed;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} tx_item_t;

	// Frame byte positions in forward mode; direct mode skips SLOT_FWD/SLOT_TID.
	typedef enum logic [3:0] {
		SLOT_START  = 4'd0,
		SLOT_LEN    = 4'd1,
		SLOT_FWD    = 4'd2,
		SLOT_TID    = 4'd3,
		SLOT_SSC    = 4'd4,
		SLOT_SPD3   = 4'd5,
		SLOT_SPD2   = 4'd6,
		SLOT_SPD1   = 4'd7,
		SLOT_SPD0   = 4'd8,
		SLOT_CRC_HI = 4'd9,
		SLOT_CRC_LO = 4'd10,
		SLOT_END    = 4'd11
	} slot_t;

	localparam logic [7:0] LEN_DIRECT  = 8'd5;
	localparam logic [7:0] LEN_FORWARD = 8'd7;

endpackage : scfb_pkg
`default_nettype wire

/* src/scfb_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_cfg_regs: configuration registers
// Four byte-wide registers written through a plain write port.
// ----------------------------------------------------------------------------
module scfb_cfg_regs
	import scfb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	output cfg_regs_t                cfg
);

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte     <= 8'd2;
			cfg_q.end_byte       <= 8'd3;
			cfg_q.set_speed_code <= 8'd8;
			cfg_q.forward_code   <= 8'd34;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_BYTE:     cfg_q.start_byte     <= cfg_wdata;
				CFG_END_BYTE:       cfg_q.end_byte       <= cfg_wdata;
				CFG_SET_SPEED_CODE: cfg_q.set_speed_code <= cfg_wdata;
				CFG_FORWARD_CODE:   cfg_q.forward_code   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : scfb_cfg_regs
`default_nettype wire

/* src/scfb_cmd_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_cmd_reg: command input register
// Holds one command beat until the serializer takes it.
// ----------------------------------------------------------------------------
module scfb_cmd_reg
	import scfb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_data,
	input  wire logic      pop,
	output logic           full,
	output cmd_item_t      cmd
);

	logic      full_s1;
	cmd_item_t cmd_s1;
	logic      accept;

	assign cmd_stall = full_s1 && !pop;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_s1 <= 1'b0;
		end else if (accept) begin
			full_s1 <= 1'b1;
		end else if (pop) begin
			full_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_data;
		end
	end

	assign full = full_s1;
	assign cmd  = cmd_s1;

endmodule : scfb_cmd_reg
`default_nettype wire

/* src/scfb_serializer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_serializer: frame byte sequencer
// Walks the frame slots of one command, one byte per beat, folding payload
// bytes into a running CRC-16 (poly 0x1021, init 0) on the way out.
// ----------------------------------------------------------------------------
module scfb_serializer
	import scfb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_regs_t cfg,
	input  wire logic      cmd_full,
	input  wire cmd_item_t cmd,
	output logic           pop,
	output logic           tx_valid,
	input  wire logic      tx_stall,
	output tx_item_t       tx_data
);

	localparam logic [15:0] CrcPoly = 16'h1021;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	logic        busy_q;
	slot_t       slot_q;
	cmd_item_t   cmd_q;
	logic [15:0] crc_q;
	logic        tx_valid_q;
	tx_item_t    tx_q;

	logic        adv;
	logic        emit;
	logic        is_end;
	logic        is_payload;
	logic [7:0]  cur_byte;
	slot_t       slot_next;

	assign adv    = !tx_valid_q || !tx_stall;
	assign emit   = busy_q && adv;
	assign is_end = (slot_q == SLOT_END);
	assign pop    = cmd_full && (!busy_q || (emit && is_end));

	always_comb begin
		is_payload = 1'b0;
		cur_byte   = 8'h00;
		case (slot_q)
			SLOT_START:  cur_byte = cfg.start_byte;
			SLOT_LEN:    cur_byte = cmd_q.func ? LEN_FORWARD : LEN_DIRECT;
			SLOT_FWD: begin
				cur_byte   = cfg.forward_code;
				is_payload = 1'b1;
			end
			SLOT_TID: begin
				cur_byte   = cmd_q.target_id;
				is_payload = 1'b1;
			end
			SLOT_SSC: begin
				cur_byte   = cfg.set_speed_code;
				is_payload = 1'b1;
			end
			SLOT_SPD3: begin
				cur_byte   = cmd_q.speed[31:24];
				is_payload = 1'b1;
			end
			SLOT_SPD2: begin
				cur_byte   = cmd_q.speed[23:16];
				is_payload = 1'b1;
			end
			SLOT_SPD1: begin
				cur_byte   = cmd_q.speed[15:8];
				is_payload = 1'b1;
			end
			SLOT_SPD0: begin
				cur_byte   = cmd_q.speed[7:0];
				is_payload = 1'b1;
			end
			SLOT_CRC_HI: cur_byte = crc_q[15:8];
			SLOT_CRC_LO: cur_byte = crc_q[7:0];
			SLOT_END:    cur_byte = cfg.end_byte;
			default:     cur_byte = 8'h00;
		endcase
	end

	// direct frames skip the forward header
	always_comb begin
		if (slot_q == SLOT_LEN) begin
			slot_next = cmd_q.func ? SLOT_FWD : SLOT_SSC;
		end else begin
			slot_next = slot_t'(slot_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			slot_q     <= SLOT_START;
			tx_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				slot_q <= SLOT_START;
			end else if (emit) begin
				slot_q <= slot_next;
				if (is_end) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				tx_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
			crc_q <= 16'h0000;
		end else if (emit && is_payload) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
		if (emit) begin
			tx_q.tx_byte <= cur_byte;
			tx_q.last    <= is_end;
		end
	end

	assign tx_valid = tx_valid_q;
	assign tx_data  = tx_q;

endmodule : scfb_serializer
`default_nettype wire

/* src/speed_command_frame_builder.sv */
`default_nettype none
// The command beat is held in the input register; each frame byte is registered.
// Throughput: one byte per cycle while tx_stall is low; a direct frame has 10 bytes
// and a forward frame 12, set by the byte serializer walking the frame slots.
// The next command is held in the input register and starts with no gap.
// Reset: pipeline empty, config registers back to 2, 3, 8 and 34.
// ----------------------------------------------------------------------------
// speed_command_frame_builder: speed command framer
// Turns each speed command into a start/len/payload/CRC16/end byte frame.
// ----------------------------------------------------------------------------
module speed_command_frame_builder
	import scfb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire cmd_item_t           cmd_data,
	output logic                     tx_valid,
	input  wire logic                tx_stall,
	output tx_item_t                 tx_data,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata
);

	cfg_regs_t cfg;
	logic      pop;
	logic      cmd_full;
	cmd_item_t cmd;

	scfb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	scfb_cmd_reg u_cmd (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.pop       (pop),
		.full      (cmd_full),
		.cmd       (cmd)
	);

	scfb_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_full (cmd_full),
		.cmd      (cmd),
		.pop      (pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_data  (tx_data)
	);

endmodule : speed_command_frame_builder
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: speed command frame builder check
// Sends speed commands in direct and forward mode under several marker and
// command byte settings and checks every frame byte against a local framer
// with its own CRC-16/XMODEM. Both sides idle at random; one phase holds the
// byte side off long enough to back up the command side.
// ----------------------------------------------------------------------------
module testbench
	import scfb_pkg::*;
();

	localparam int CYCLE_LIMIT = 100000;
	localparam int IDLE_PCT = 6;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_item_t cmd_data = '0;
	logic tx_valid;
	logic tx_stall = 1'b0;
	tx_item_t tx_data;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	cfg_regs_t cfg_shadow = '{start_byte: 8'd2, end_byte: 8'd3,
		set_speed_code: 8'd8, forward_code: 8'd34};
	tx_item_t pending_bytes[$];
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit quiet = 1'b0;

	speed_command_frame_builder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.tx_valid(tx_valid),
		.tx_stall(tx_stall),
		.tx_data(tx_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] crc16_xmodem_byte(logic [15:0] crc, logic [7:0] b);
		crc = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
		end
		return crc;
	endfunction

	// Build the expected frame for one command under the current register values.
	function automatic void predict_frame(cmd_item_t c);
		logic [7:0] body[$];
		logic [7:0] frame[$];
		logic [15:0] crc;
		crc = 16'h0000;
		if (c.func) begin
			body.push_back(cfg_shadow.forward_code);
			body.push_back(c.target_id);
		end
		body.push_back(cfg_shadow.set_speed_code);
		body.push_back(c.speed[31:24]);
		body.push_back(c.speed[23:16]);
		body.push_back(c.speed[15:8]);
		body.push_back(c.speed[7:0]);
		foreach (body[i]) crc = crc16_xmodem_byte(crc, body[i]);
		frame.push_back(cfg_shadow.start_byte);
		frame.push_back(8'(body.size()));
		foreach (body[i]) frame.push_back(body[i]);
		frame.push_back(crc[15:8]);
		frame.push_back(crc[7:0]);
		frame.push_back(cfg_shadow.end_byte);
		foreach (frame[i]) pending_bytes.push_back('{tx_byte: frame[i],
			last: (i == frame.size() - 1)});
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_cmd(cmd_item_t c);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= c;
		do @(posedge clk); while (cmd_stall);
		predict_frame(c);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_START_BYTE: cfg_shadow.start_byte = value;
			CFG_END_BYTE: cfg_shadow.end_byte = value;
			CFG_SET_SPEED_CODE: cfg_shadow.set_speed_code = value;
			CFG_FORWARD_CODE: cfg_shadow.forward_code = value;
			default: ;
		endcase
	endtask

	task automatic write_config(cfg_regs_t v);
		put_reg(CFG_START_BYTE, v.start_byte);
		put_reg(CFG_END_BYTE, v.end_byte);
		put_reg(CFG_SET_SPEED_CODE, v.set_speed_code);
		put_reg(CFG_FORWARD_CODE, v.forward_code);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_reg_value();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic cmd_item_t rand_cmd();
		cmd_item_t c;
		c.func = 1'($urandom_range(1));
		c.target_id = 8'($urandom_range(0, 255));
		case ($urandom_range(11))
			0: c.speed = 32'h7FFF_FFFF;
			1: c.speed = 32'h8000_0000;
			2: c.speed = 32'h0000_0000;
			3: c.speed = 32'hFFFF_FFFF;
			4: c.speed = $urandom_range(0, 6000);
			5: c.speed = -$signed({1'b0, 31'($urandom_range(0, 6000))});
			default: c.speed = $urandom;
		endcase
		return c;
	endfunction

	task automatic test_reset_config();
		send_cmd('{func: 1'b0, target_id: 8'h00, speed: 32'sd0});
		send_cmd('{func: 1'b1, target_id: 8'hFF, speed: 32'sd0});
		send_cmd('{func: 1'b0, target_id: 8'hFF, speed: 32'h7FFF_FFFF});
		send_cmd('{func: 1'b1, target_id: 8'h00, speed: 32'h8000_0000});
		send_cmd('{func: 1'b0, target_id: 8'hA5, speed: 32'hFFFF_FFFF});
		send_cmd('{func: 1'b1, target_id: 8'h5A, speed: 32'sd1500});
		send_cmd('{func: 1'b1, target_id: 8'h01, speed: -32'sd1500});
		drain();
	endtask

	task automatic test_config_extremes();
		write_config('{start_byte: 8'h00, end_byte: 8'h00,
			set_speed_code: 8'h00, forward_code: 8'h00});
		send_cmd('{func: 1'b0, target_id: 8'h00, speed: 32'h8000_0000});
		send_cmd('{func: 1'b1, target_id: 8'hFF, speed: 32'h7FFF_FFFF});
		send_cmd('{func: 1'b1, target_id: 8'h00, speed: 32'sd0});
		drain();
		write_config('{start_byte: 8'hFF, end_byte: 8'hFF,
			set_speed_code: 8'hFF, forward_code: 8'hFF});
		send_cmd('{func: 1'b0, target_id: 8'h33, speed: 32'hFFFF_FFFF});
		send_cmd('{func: 1'b1, target_id: 8'hFF, speed: 32'h8000_0000});
		send_cmd('{func: 1'b1, target_id: 8'h80, speed: 32'h5555_AAAA});
		drain();
		write_config('{start_byte: 8'h7E, end_byte: 8'h81,
			set_speed_code: 8'hAA, forward_code: 8'h55});
		send_cmd('{func: 1'b0, target_id: 8'h12, speed: 32'hAAAA_5555});
		send_cmd('{func: 1'b1, target_id: 8'h7F, speed: 32'h0123_4567});
		drain();
	endtask

	// Byte side held off long enough for the command side to stall.
	task automatic test_backpressure();
		hold_left = 300;
		repeat (12) send_cmd(rand_cmd());
		drain();
	endtask

	task automatic test_random_commands();
		for (int phase = 0; phase < 5; phase++) begin
			write_config('{start_byte: rand_reg_value(), end_byte: rand_reg_value(),
				set_speed_code: rand_reg_value(), forward_code: rand_reg_value()});
			quiet = (phase == 2);
			repeat (100) send_cmd(rand_cmd());
			drain();
		end
		quiet = 1'b0;
	endtask

	// Byte side: random stalls, a quiet stretch, and the long hold-off.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				tx_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				tx_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_valid && !tx_stall) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: expected no beat, actual byte %h last %b", $time,
					tx_data.tx_byte, tx_data.last);
			end else begin
				if (tx_data.tx_byte !== pending_bytes[0].tx_byte) begin
					mismatches++;
					$display("%0t: tx_byte expected %h actual %h", $time,
						pending_bytes[0].tx_byte, tx_data.tx_byte);
				end
				if (tx_data.last !== pending_bytes[0].last) begin
					mismatches++;
					$display("%0t: last expected %b actual %b", $time,
						pending_bytes[0].last, tx_data.last);
				end
				void'(pending_bytes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_config_extremes();
		test_backpressure();
		test_random_commands();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
